// ----- src/rgbbl_pkg.sv -----
`default_nettype none

package rgbbl_pkg;

    // blend modes, coded as written to the mode register
    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_MULTIPLY = 2'd2,
        MODE_AVERAGE  = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_FACTOR = 1'b1;

    localparam int CFG_DATA_W = 9;

    localparam logic [8:0]  FACTOR_ONE  = 9'd256;
    localparam logic [7:0]  CH_MAX      = 8'd255;
    localparam logic [15:0] MUL_SCALE   = 16'd65280;
    // floor(q / 255) == (q * RECIP_255) >> 23 for any 16-bit q
    localparam logic [15:0] RECIP_255   = 16'h8081;

    typedef struct packed {
        logic [7:0] left_red;
        logic [7:0] left_green;
        logic [7:0] left_blue;
        logic [7:0] right_red;
        logic [7:0] right_green;
        logic [7:0] right_blue;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_out;
    } out_item_t;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

`default_nettype wire

// ----- src/rgb8_blend_modes_top.sv -----
`default_nettype none

// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------
// pixel in | src_valid / src_stall     | src_item (left and right rgb)
// pixel out| dst_valid / dst_stall     | dst_item (blended rgb, last)
// config   | cfg_we, cfg_index         | cfg_data (mode or factor)
//
// four register stages, one item per cycle while dst_stall is low
// stages: factor products, linear finish or scale product, divide by 255, output
// each stage loads when it is empty or its successor loads, so bubbles close up
// under an output stall and the pipe keeps taking items until all four stages hold one
// reset clears the valid bits and sets mode to add and factor to one

module rgb8_blend_modes_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    output logic                     src_stall,
    input  wire rgbbl_pkg::in_item_t src_item,
    output logic                     dst_valid,
    input  wire logic                dst_stall,
    output rgbbl_pkg::out_item_t     dst_item,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [rgbbl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rgbbl_pkg::*;

    // configuration registers
    mode_t      mode_reg;
    logic [8:0] factor_reg;
    logic [8:0] factor_clamped;

    // valid bits travelling with the data
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;

    // last-pixel flag alongside the channels
    logic last1_reg;
    logic last2_reg;
    logic last3_reg;
    logic last4_reg;

    pipe_en_t en;

    logic [7:0] red_res;
    logic [7:0] green_res;
    logic [7:0] blue_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ADD;
            factor_reg <= FACTOR_ONE;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDX_MODE)
            begin
                mode_reg <= mode_t'(cfg_data[1:0]);
            end
            else
            begin
                factor_reg <= cfg_data;
            end
        end
    end

    // strength above one means full strength
    assign factor_clamped = (factor_reg > FACTOR_ONE) ? FACTOR_ONE : factor_reg;

    // load enables, from the output backwards
    always_comb
    begin
        en.s4 = !v4_reg || !dst_stall;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign src_stall = !en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= src_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            last1_reg <= src_item.last_in;
        end
        if (en.s2)
        begin
            last2_reg <= last1_reg;
        end
        if (en.s3)
        begin
            last3_reg <= last2_reg;
        end
        if (en.s4)
        begin
            last4_reg <= last3_reg;
        end
    end

    // one datapath per colour channel
    rgbbl_chan u_red (
        .clk    (clk),
        .en     (en),
        .mode   (mode_reg),
        .factor (factor_clamped),
        .left   (src_item.left_red),
        .right  (src_item.right_red),
        .result (red_res)
    );

    rgbbl_chan u_green (
        .clk    (clk),
        .en     (en),
        .mode   (mode_reg),
        .factor (factor_clamped),
        .left   (src_item.left_green),
        .right  (src_item.right_green),
        .result (green_res)
    );

    rgbbl_chan u_blue (
        .clk    (clk),
        .en     (en),
        .mode   (mode_reg),
        .factor (factor_clamped),
        .left   (src_item.left_blue),
        .right  (src_item.right_blue),
        .result (blue_res)
    );

    assign dst_valid          = v4_reg;
    assign dst_item.out_red   = red_res;
    assign dst_item.out_green = green_res;
    assign dst_item.out_blue  = blue_res;
    assign dst_item.last_out  = last4_reg;

endmodule

`default_nettype wire

// ----- src/rgbbl_chan.sv -----
`default_nettype none

module rgbbl_chan (
    input  wire logic              clk,
    input  wire rgbbl_pkg::pipe_en_t en,
    input  wire rgbbl_pkg::mode_t  mode,
    input  wire logic [8:0]        factor,
    input  wire logic [7:0]        left,
    input  wire logic [7:0]        right,
    output logic [7:0]             result
);
    import rgbbl_pkg::*;

    // stage 1 signals
    logic [8:0]  pair_sum;
    logic [7:0]  sub_base;
    logic [8:0]  mul_a;
    logic [8:0]  mul_b;
    logic [8:0]  factor_inv;
    logic [17:0] t1_next;
    logic [17:0] t2_next;

    logic [17:0] t1_reg;
    logic [17:0] t2_reg;
    logic [7:0]  left1_reg;
    mode_t       mode1_reg;

    // stage 2 signals
    logic [18:0] mix_sum;
    logic [10:0] add_sum;
    logic [15:0] mul_scale_x;
    logic [23:0] mul_prod;
    logic [7:0]  lin_next;

    logic [7:0]  lin2_reg;
    logic [15:0] quot2_reg;
    mode_t       mode2_reg;

    // stage 3 signals
    logic [31:0] recip_prod;

    logic [7:0]  lin3_reg;
    logic [7:0]  mulres3_reg;
    mode_t       mode3_reg;

    logic [7:0]  result_reg;
    logic [7:0]  result_next;

    // stage 1: operand selection and the two factor products
    always_comb
    begin
        pair_sum   = {1'b0, left} + {1'b0, right};
        sub_base   = (pair_sum > {1'b0, CH_MAX}) ? 8'(pair_sum - {1'b0, CH_MAX}) : 8'd0;
        factor_inv = FACTOR_ONE - factor;
        unique case (mode)
            MODE_ADD:
            begin
                mul_a = {1'b0, right};
                mul_b = 9'd0;
            end
            MODE_SUBTRACT:
            begin
                mul_a = {1'b0, sub_base};
                mul_b = {1'b0, left};
            end
            MODE_MULTIPLY:
            begin
                mul_a = {1'b0, CH_MAX - right};
                mul_b = 9'd0;
            end
            MODE_AVERAGE:
            begin
                mul_a = pair_sum;
                mul_b = {left, 1'b0};
            end
            default:
            begin
                mul_a = 9'd0;
                mul_b = 9'd0;
            end
        endcase
        t1_next = mul_a * factor;
        t2_next = mul_b * factor_inv;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            left1_reg <= left;
            mode1_reg <= mode;
        end
    end

    // stage 2: linear modes finish, multiply mode takes its second product
    always_comb
    begin
        mix_sum     = {1'b0, t1_reg} + {1'b0, t2_reg};
        add_sum     = {3'b000, left1_reg} + {1'b0, t1_reg[17:8]};
        mul_scale_x = MUL_SCALE - t1_reg[15:0];
        mul_prod    = left1_reg * mul_scale_x;
        case (mode1_reg)
            MODE_ADD:      lin_next = (add_sum > {3'b000, CH_MAX}) ? CH_MAX : add_sum[7:0];
            MODE_SUBTRACT: lin_next = mix_sum[15:8];
            MODE_AVERAGE:  lin_next = mix_sum[16:9];
            default:       lin_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            lin2_reg  <= lin_next;
            quot2_reg <= mul_prod[23:8];
            mode2_reg <= mode1_reg;
        end
    end

    // stage 3: divide by 255 through the reciprocal
    assign recip_prod = quot2_reg * RECIP_255;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            lin3_reg    <= lin2_reg;
            mulres3_reg <= recip_prod[30:23];
            mode3_reg   <= mode2_reg;
        end
    end

    // stage 4: output register
    assign result_next = (mode3_reg == MODE_MULTIPLY) ? mulres3_reg : lin3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
